// ===== hdl/kalp_pkg.sv =====
// ---------------------------------------------------------------------------
// kalp_pkg
// Shared types and constants for the polar track Kalman update pipeline.
// ---------------------------------------------------------------------------
package kalp_pkg;

	localparam int DATA_W    = 16;
	localparam int VAR_W     = 24;
	localparam int PVAR_W    = VAR_W + 1;
	localparam int PRED_W    = 26;
	localparam int CFG_IDX_W = 3;

	// Divider geometry: numerator magnitude, quotient bits, doubled denominator.
	localparam int DIV_NW = 51;
	localparam int DIV_QW = 26;
	localparam int DIV_DW = 27;

	localparam int FRONT_LAT = 4;
	localparam int BACK_LAT  = 4;

	// Angles are Q2.13.
	localparam int PI_Q      = 25736;
	localparam int TWO_PI_Q  = 51472;
	localparam int NEAR_PI_Q = 82;

	// Final wrap: bias is a multiple of two pi, reciprocal is floor(2^42 / 2pi).
	localparam int  WRAP_BIAS   = 13176832;
	localparam int  RECIP_Q     = 85445417;
	localparam int  RECIP_W     = 27;
	localparam int  RECIP_SHIFT = 42;
	localparam int  WRAP_W      = 26;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PN_RANGE,
		CFG_PN_ANGLE,
		CFG_MN_RANGE,
		CFG_MN_ANGLE,
		CFG_RV_LIMIT,
		CFG_AV_LIMIT
	} cfg_idx_t;

	typedef struct packed {
		logic [VAR_W-1:0] pn_range;
		logic [VAR_W-1:0] pn_angle;
		logic [VAR_W-1:0] mn_range;
		logic [VAR_W-1:0] mn_angle;
		logic [VAR_W-1:0] rv_limit;
		logic [VAR_W-1:0] av_limit;
	} kalp_cfg_t;

	// Everything the back end needs besides the four quotients and two remainder flags.
	typedef struct packed {
		logic                     has_meas;
		logic                     zero_r;
		logic                     zero_a;
		logic                     neg_r;
		logic                     neg_a;
		logic signed [PRED_W-1:0] xr;
		logic signed [PRED_W-1:0] xa;
		logic [PVAR_W-1:0]        pr;
		logic [PVAR_W-1:0]        pa;
	} kalp_side_t;

endpackage

// ===== hdl/kalp_divider.sv =====
// ---------------------------------------------------------------------------
// kalp_divider
// Pipelined restoring divider, one quotient bit per stage.
// ---------------------------------------------------------------------------
module kalp_divider #(
	parameter int NW = 51,
	parameter int QW = 26,
	parameter int DW = 27
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          out_valid,
	output logic [QW-1:0] quot,
	output logic          rem_nz
);

	logic [DW-1:0] rem_s [QW];
	logic [QW-1:0] low_s [QW];
	logic [QW-1:0] quo_s [QW];
	logic [DW-1:0] den_s [QW];
	logic [QW-1:0] vld_s;

	logic [DW-1:0] rem_in [QW];
	logic [QW-1:0] low_in [QW];
	logic [QW-1:0] quo_in [QW];
	logic [DW-1:0] den_in [QW];
	logic [DW-1:0] rem_d  [QW];
	logic [QW-1:0] quo_d  [QW];

	// The caller guarantees the quotient fits in QW bits, so the upper part
	// of the numerator is already below the divisor.
	always_comb begin
		logic [DW:0] trial;
		logic        ge;
		rem_in[0] = DW'(num[NW-1:QW]);
		low_in[0] = num[QW-1:0];
		quo_in[0] = '0;
		den_in[0] = den;
		for (int i = 1; i < QW; i++) begin
			rem_in[i] = rem_s[i-1];
			low_in[i] = low_s[i-1];
			quo_in[i] = quo_s[i-1];
			den_in[i] = den_s[i-1];
		end
		for (int i = 0; i < QW; i++) begin
			trial = {rem_in[i], low_in[i][QW-1]};
			ge = (trial >= {1'b0, den_in[i]});
			rem_d[i] = ge ? DW'(trial - {1'b0, den_in[i]}) : trial[DW-1:0];
			quo_d[i] = {quo_in[i][QW-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[QW-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < QW; i++) begin
			rem_s[i] <= rem_d[i];
			low_s[i] <= {low_in[i][QW-2:0], 1'b0};
			quo_s[i] <= quo_d[i];
			den_s[i] <= den_in[i];
		end
	end

	assign out_valid = vld_s[QW-1];
	assign quot      = quo_s[QW-1];
	assign rem_nz    = |rem_s[QW-1];

endmodule

// ===== hdl/kalp_front.sv =====
// ---------------------------------------------------------------------------
// kalp_front
// Input wrap, prediction and gain numerators; four stages feeding the dividers.
// ---------------------------------------------------------------------------
module kalp_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  kalp_pkg::kalp_cfg_t                 cfg,
	input  logic                                in_valid,
	input  logic signed [kalp_pkg::DATA_W-1:0]  track_range,
	input  logic signed [kalp_pkg::DATA_W-1:0]  track_angle,
	input  logic [kalp_pkg::VAR_W-1:0]          track_range_var,
	input  logic [kalp_pkg::VAR_W-1:0]          track_angle_var,
	input  logic signed [kalp_pkg::DATA_W-1:0]  meas_range,
	input  logic signed [kalp_pkg::DATA_W-1:0]  meas_angle,
	input  logic signed [kalp_pkg::DATA_W-1:0]  linear_velocity,
	input  logic signed [kalp_pkg::DATA_W-1:0]  angular_velocity,
	input  logic [kalp_pkg::DATA_W-1:0]         elapsed_time,
	output logic                                out_valid,
	output kalp_pkg::kalp_side_t                side,
	output logic [kalp_pkg::DIV_NW-1:0]         num_vr,
	output logic [kalp_pkg::DIV_NW-1:0]         num_va,
	output logic [kalp_pkg::DIV_NW-1:0]         num_xr,
	output logic [kalp_pkg::DIV_NW-1:0]         num_xa,
	output logic [kalp_pkg::DIV_DW-1:0]         den_r,
	output logic [kalp_pkg::DIV_DW-1:0]         den_a
);

	import kalp_pkg::*;

	localparam int PROD_W = 2 * DATA_W + 1;
	localparam int DIFF_W = PRED_W + 1;
	localparam int DEN_W  = DIV_DW - 1;
	localparam int NV_W   = PVAR_W + VAR_W;
	localparam int NX_W   = PVAR_W + 1 + DIFF_W;
	localparam logic signed [17:0] PI_S     = 18'(PI_Q);
	localparam logic signed [17:0] TWO_PI_S = 18'(TWO_PI_Q);

	function automatic logic signed [DATA_W-1:0] wrap_in(input logic signed [DATA_W-1:0] a);
		logic signed [17:0] w;
		w = 18'(a);
		if (w > PI_S) begin
			w = w - TWO_PI_S;
		end else if (w <= -PI_S) begin
			w = w + TWO_PI_S;
		end
		return w[DATA_W-1:0];
	endfunction

	// Stage 1: wrap the angles, velocity times time, predicted variances.
	logic                     v_s1;
	logic signed [DATA_W-1:0] tr_s1, ta_s1, mr_s1, ma_s1;
	logic signed [PROD_W-1:0] prod_r_s1, prod_a_s1;
	logic [PVAR_W-1:0]        pr_s1, pa_s1;

	// Stage 2: predicted state, innovation, gain denominators.
	logic                     v_s2, has_s2;
	logic signed [PRED_W-1:0] xr_s2, xa_s2;
	logic signed [DIFF_W-1:0] diff_r_s2, diff_a_s2;
	logic [DEN_W-1:0]         den_r_s2, den_a_s2;
	logic [PVAR_W-1:0]        pr_s2, pa_s2;

	// Stage 3: products P*R and P*(z - x).
	logic                     v_s3, has_s3;
	logic signed [PRED_W-1:0] xr_s3, xa_s3;
	logic [NV_W-1:0]          nv_r_s3, nv_a_s3;
	logic signed [NX_W-1:0]   nx_r_s3, nx_a_s3;
	logic [DEN_W-1:0]         den_r_s3, den_a_s3;
	logic [PVAR_W-1:0]        pr_s3, pa_s3;

	// Stage 4: rounding numerators 2n + d and divisors 2d.
	logic                     v_s4;
	kalp_side_t               side_s4;
	logic [DIV_NW-1:0]        num_vr_s4, num_va_s4, num_xr_s4, num_xa_s4;
	logic [DIV_DW-1:0]        den_r_s4, den_a_s4;

	logic signed [PROD_W-1:0] rnd_r, rnd_a;
	logic signed [PRED_W-1:0] xr_pre, xa_pre;
	logic signed [NX_W:0]     nxr_full, nxa_full, nxr_mag, nxa_mag;

	assign rnd_r = (prod_r_s1 + PROD_W'(128)) >>> 8;
	assign rnd_a = (prod_a_s1 + PROD_W'(128)) >>> 8;

	assign xr_pre = PRED_W'(tr_s1) + PRED_W'(rnd_r);
	assign xa_pre = PRED_W'(ta_s1) + PRED_W'(rnd_a);

	assign nxr_full = {nx_r_s3, 1'b0} + $signed((NX_W + 1)'(den_r_s3));
	assign nxa_full = {nx_a_s3, 1'b0} + $signed((NX_W + 1)'(den_a_s3));
	assign nxr_mag  = nxr_full[NX_W] ? -nxr_full : nxr_full;
	assign nxa_mag  = nxa_full[NX_W] ? -nxa_full : nxa_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		tr_s1     <= track_range;
		ta_s1     <= wrap_in(track_angle);
		mr_s1     <= meas_range;
		ma_s1     <= wrap_in(meas_angle);
		prod_r_s1 <= linear_velocity * $signed({1'b0, elapsed_time});
		prod_a_s1 <= angular_velocity * $signed({1'b0, elapsed_time});
		pr_s1     <= PVAR_W'(track_range_var) + PVAR_W'(cfg.pn_range);
		pa_s1     <= PVAR_W'(track_angle_var) + PVAR_W'(cfg.pn_angle);

		xr_s2     <= xr_pre;
		xa_s2     <= xa_pre;
		diff_r_s2 <= DIFF_W'(mr_s1) - DIFF_W'(xr_pre);
		diff_a_s2 <= DIFF_W'(ma_s1) - DIFF_W'(xa_pre);
		den_r_s2  <= DEN_W'(pr_s1) + DEN_W'(cfg.mn_range);
		den_a_s2  <= DEN_W'(pa_s1) + DEN_W'(cfg.mn_angle);
		has_s2    <= (mr_s1 > 16'sd0);
		pr_s2     <= pr_s1;
		pa_s2     <= pa_s1;

		xr_s3     <= xr_s2;
		xa_s3     <= xa_s2;
		nv_r_s3   <= NV_W'(pr_s2) * NV_W'(cfg.mn_range);
		nv_a_s3   <= NV_W'(pa_s2) * NV_W'(cfg.mn_angle);
		nx_r_s3   <= $signed({1'b0, pr_s2}) * diff_r_s2;
		nx_a_s3   <= $signed({1'b0, pa_s2}) * diff_a_s2;
		den_r_s3  <= den_r_s2;
		den_a_s3  <= den_a_s2;
		has_s3    <= has_s2;
		pr_s3     <= pr_s2;
		pa_s3     <= pa_s2;

		num_vr_s4 <= DIV_NW'({nv_r_s3, 1'b0}) + DIV_NW'(den_r_s3);
		num_va_s4 <= DIV_NW'({nv_a_s3, 1'b0}) + DIV_NW'(den_a_s3);
		num_xr_s4 <= nxr_mag[DIV_NW-1:0];
		num_xa_s4 <= nxa_mag[DIV_NW-1:0];
		den_r_s4  <= {den_r_s3, 1'b0};
		den_a_s4  <= {den_a_s3, 1'b0};
		side_s4.has_meas <= has_s3;
		side_s4.zero_r   <= (den_r_s3 == '0);
		side_s4.zero_a   <= (den_a_s3 == '0);
		side_s4.neg_r    <= nxr_full[NX_W];
		side_s4.neg_a    <= nxa_full[NX_W];
		side_s4.xr       <= xr_s3;
		side_s4.xa       <= xa_s3;
		side_s4.pr       <= pr_s3;
		side_s4.pa       <= pa_s3;
	end

	assign out_valid = v_s4;
	assign side      = side_s4;
	assign num_vr    = num_vr_s4;
	assign num_va    = num_va_s4;
	assign num_xr    = num_xr_s4;
	assign num_xa    = num_xa_s4;
	assign den_r     = den_r_s4;
	assign den_a     = den_a_s4;

endmodule

// ===== hdl/kalp_back.sv =====
// ---------------------------------------------------------------------------
// kalp_back
// Applies the corrections, saturates, gates and wraps the final bearing.
// ---------------------------------------------------------------------------
module kalp_back (
	input  logic                               clk,
	input  logic                               arst_n,
	input  kalp_pkg::kalp_cfg_t                cfg,
	input  logic                               in_valid,
	input  kalp_pkg::kalp_side_t               side,
	input  logic [kalp_pkg::DIV_QW-1:0]        q_vr,
	input  logic [kalp_pkg::DIV_QW-1:0]        q_va,
	input  logic [kalp_pkg::DIV_QW-1:0]        q_xr,
	input  logic [kalp_pkg::DIV_QW-1:0]        q_xa,
	input  logic                               nz_xr,
	input  logic                               nz_xa,
	output logic                               done,
	output logic signed [kalp_pkg::DATA_W-1:0] new_range,
	output logic signed [kalp_pkg::DATA_W-1:0] new_angle,
	output logic [kalp_pkg::VAR_W-1:0]         new_range_var,
	output logic [kalp_pkg::VAR_W-1:0]         new_angle_var,
	output logic                               keep_track
);

	import kalp_pkg::*;

	localparam int XW     = PRED_W + 2;
	localparam int MUL_W  = WRAP_W + RECIP_W;
	localparam int K_W    = MUL_W - RECIP_SHIFT;
	localparam int R_W    = 17;
	localparam logic [RECIP_W-1:0]    RECIP_C  = RECIP_W'(RECIP_Q);
	localparam logic [R_W-1:0]        TWO_PI_R = R_W'(TWO_PI_Q);
	localparam logic signed [R_W-1:0] PI_R     = R_W'(PI_Q);
	localparam logic signed [R_W-1:0] NEAR_R   = R_W'(NEAR_PI_Q);
	localparam logic signed [XW-1:0]  BIAS_X   = XW'(PI_Q + WRAP_BIAS);
	localparam logic signed [XW-1:0]  SAT_HI   = XW'(32767);
	localparam logic signed [XW-1:0]  SAT_LO   = -XW'(32768);

	logic [DIV_QW:0]          qm_r, qm_a;
	logic signed [DIV_QW:0]   qs_r, qs_a;
	logic signed [XW-1:0]     xr_new, xa_new, m_full;
	logic [PVAR_W-1:0]        pr_new, pa_new;
	logic [VAR_W-1:0]         prs, pas;
	logic signed [DATA_W-1:0] xr_sat;

	// The quotient came from magnitudes; floor of a negative value rounds away.
	always_comb begin
		qm_r = {1'b0, q_xr};
		qm_a = {1'b0, q_xa};
		qs_r = side.neg_r ? -$signed(qm_r + (DIV_QW + 1)'(nz_xr)) : $signed(qm_r);
		qs_a = side.neg_a ? -$signed(qm_a + (DIV_QW + 1)'(nz_xa)) : $signed(qm_a);
		xr_new = XW'(side.xr);
		xa_new = XW'(side.xa);
		pr_new = side.pr;
		pa_new = side.pa;
		if (side.has_meas) begin
			if (side.zero_r) begin
				pr_new = '0;
			end else begin
				xr_new = xr_new + XW'(qs_r);
				pr_new = q_vr[PVAR_W-1:0];
			end
			if (side.zero_a) begin
				pa_new = '0;
			end else begin
				xa_new = xa_new + XW'(qs_a);
				pa_new = q_va[PVAR_W-1:0];
			end
		end
		if (xr_new > SAT_HI) begin
			xr_sat = 16'sh7fff;
		end else if (xr_new < SAT_LO) begin
			xr_sat = -16'sh8000;
		end else begin
			xr_sat = xr_new[DATA_W-1:0];
		end
		prs    = pr_new[VAR_W] ? '1 : pr_new[VAR_W-1:0];
		pas    = pa_new[VAR_W] ? '1 : pa_new[VAR_W-1:0];
		m_full = BIAS_X - xa_new;
	end

	logic                     v_s1, v_s2, v_s3, v_s4;
	logic signed [DATA_W-1:0] range_s1, range_s2, range_s3, range_s4;
	logic [VAR_W-1:0]         rvar_s1, rvar_s2, rvar_s3, rvar_s4;
	logic [VAR_W-1:0]         avar_s1, avar_s2, avar_s3, avar_s4;
	logic                     keep_s1, keep_s2, keep_s3, keep_s4;
	logic [WRAP_W-1:0]        m_s1, m_s2;
	logic [MUL_W-1:0]         prod_s2;
	logic [R_W-1:0]           r_s3;
	logic signed [DATA_W-1:0] angle_s4;

	logic [K_W-1:0]           k_est;
	logic [R_W-1:0]           t_red;
	logic signed [R_W-1:0]    xa_w, xa_fin;

	assign k_est = prod_s2[MUL_W-1:RECIP_SHIFT];

	// The reciprocal estimate is at most one low, so one subtract finishes it.
	always_comb begin
		t_red  = (r_s3 >= TWO_PI_R) ? r_s3 - TWO_PI_R : r_s3;
		xa_w   = PI_R - $signed(t_red);
		xa_fin = (xa_w + PI_R < NEAR_R) ? -xa_w : xa_w;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		range_s1 <= xr_sat;
		rvar_s1  <= prs;
		avar_s1  <= pas;
		keep_s1  <= (prs < cfg.rv_limit) && (pas < cfg.av_limit);
		m_s1     <= m_full[WRAP_W-1:0];

		range_s2 <= range_s1;
		rvar_s2  <= rvar_s1;
		avar_s2  <= avar_s1;
		keep_s2  <= keep_s1;
		m_s2     <= m_s1;
		prod_s2  <= MUL_W'(m_s1) * MUL_W'(RECIP_C);

		range_s3 <= range_s2;
		rvar_s3  <= rvar_s2;
		avar_s3  <= avar_s2;
		keep_s3  <= keep_s2;
		r_s3     <= R_W'(m_s2 - WRAP_W'(WRAP_W'(k_est) * WRAP_W'(TWO_PI_R)));

		range_s4 <= range_s3;
		rvar_s4  <= rvar_s3;
		avar_s4  <= avar_s3;
		keep_s4  <= keep_s3;
		angle_s4 <= xa_fin[DATA_W-1:0];
	end

	assign done          = v_s4;
	assign new_range     = range_s4;
	assign new_angle     = angle_s4;
	assign new_range_var = rvar_s4;
	assign new_angle_var = avar_s4;
	assign keep_track    = keep_s4;

endmodule

// ===== hdl/polar_track_kalman_update.sv =====
// ---------------------------------------------------------------------------
// polar_track_kalman_update
// Two-state diagonal Kalman update of one polar track per cycle.
// ---------------------------------------------------------------------------
// Usage:
// A track beat is taken at a rising edge with start high and busy low; busy
// is never raised, so a new track may enter on every cycle. All fields of the
// track, the measurement and the motion input arrive together with start.
// The updated track leaves the pipeline as one beat: done is high for one
// cycle with new_range, new_angle, both variances and keep_track valid.
// The pipeline is four front stages (angle wrap and velocity products,
// prediction, gain products, rounding numerators), 26 stages of the four
// pipelined dividers (one quotient bit per stage) and four back stages
// (correction and saturation, a reciprocal multiply and two steps of the
// final angle wrap). Throughput is one track per cycle.
// The receiver cannot hold results off; every beat must be taken as it comes.
// Configuration registers are written through cfg_we, cfg_index and cfg_data
// while no track is in flight; indexes past the last register are ignored.
// Reset clears the pipeline valid bits and loads the default noise values
// and variance limits; tracks in flight at reset are dropped.
// ---------------------------------------------------------------------------
module polar_track_kalman_update (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic                               cfg_we,
	input  logic [kalp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [kalp_pkg::VAR_W-1:0]         cfg_data,
	input  logic signed [kalp_pkg::DATA_W-1:0] track_range,
	input  logic signed [kalp_pkg::DATA_W-1:0] track_angle,
	input  logic [kalp_pkg::VAR_W-1:0]         track_range_var,
	input  logic [kalp_pkg::VAR_W-1:0]         track_angle_var,
	input  logic signed [kalp_pkg::DATA_W-1:0] meas_range,
	input  logic signed [kalp_pkg::DATA_W-1:0] meas_angle,
	input  logic signed [kalp_pkg::DATA_W-1:0] linear_velocity,
	input  logic signed [kalp_pkg::DATA_W-1:0] angular_velocity,
	input  logic [kalp_pkg::DATA_W-1:0]        elapsed_time,
	output logic                               done,
	output logic signed [kalp_pkg::DATA_W-1:0] new_range,
	output logic signed [kalp_pkg::DATA_W-1:0] new_angle,
	output logic [kalp_pkg::VAR_W-1:0]         new_range_var,
	output logic [kalp_pkg::VAR_W-1:0]         new_angle_var,
	output logic                               keep_track
);

	import kalp_pkg::*;

	localparam int LATENCY = FRONT_LAT + DIV_QW + BACK_LAT;

	kalp_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pn_range <= VAR_W'(458752);
			cfg_q.pn_angle <= VAR_W'(1144);
			cfg_q.mn_range <= VAR_W'(458752);
			cfg_q.mn_angle <= VAR_W'(1144);
			cfg_q.rv_limit <= VAR_W'(2293760);
			cfg_q.av_limit <= VAR_W'(5719);
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_PN_RANGE: cfg_q.pn_range <= cfg_data;
				CFG_PN_ANGLE: cfg_q.pn_angle <= cfg_data;
				CFG_MN_RANGE: cfg_q.mn_range <= cfg_data;
				CFG_MN_ANGLE: cfg_q.mn_angle <= cfg_data;
				CFG_RV_LIMIT: cfg_q.rv_limit <= cfg_data;
				CFG_AV_LIMIT: cfg_q.av_limit <= cfg_data;
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	logic              fr_valid;
	kalp_side_t        fr_side;
	logic [DIV_NW-1:0] num_vr, num_va, num_xr, num_xa;
	logic [DIV_DW-1:0] den_r, den_a;

	kalp_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg_q),
		.in_valid         (start && !busy),
		.track_range      (track_range),
		.track_angle      (track_angle),
		.track_range_var  (track_range_var),
		.track_angle_var  (track_angle_var),
		.meas_range       (meas_range),
		.meas_angle       (meas_angle),
		.linear_velocity  (linear_velocity),
		.angular_velocity (angular_velocity),
		.elapsed_time     (elapsed_time),
		.out_valid        (fr_valid),
		.side             (fr_side),
		.num_vr           (num_vr),
		.num_va           (num_va),
		.num_xr           (num_xr),
		.num_xa           (num_xa),
		.den_r            (den_r),
		.den_a            (den_a)
	);

	logic              dv_vr, dv_va, dv_xr, dv_xa;
	logic              nz_vr, nz_va, nz_xr, nz_xa;
	logic [DIV_QW-1:0] q_vr, q_va, q_xr, q_xa;

	kalp_divider #(.NW(DIV_NW), .QW(DIV_QW), .DW(DIV_DW)) u_div_vr (
		.clk (clk), .arst_n (arst_n), .in_valid (fr_valid), .num (num_vr), .den (den_r),
		.out_valid (dv_vr), .quot (q_vr), .rem_nz (nz_vr)
	);
	kalp_divider #(.NW(DIV_NW), .QW(DIV_QW), .DW(DIV_DW)) u_div_va (
		.clk (clk), .arst_n (arst_n), .in_valid (fr_valid), .num (num_va), .den (den_a),
		.out_valid (dv_va), .quot (q_va), .rem_nz (nz_va)
	);
	kalp_divider #(.NW(DIV_NW), .QW(DIV_QW), .DW(DIV_DW)) u_div_xr (
		.clk (clk), .arst_n (arst_n), .in_valid (fr_valid), .num (num_xr), .den (den_r),
		.out_valid (dv_xr), .quot (q_xr), .rem_nz (nz_xr)
	);
	kalp_divider #(.NW(DIV_NW), .QW(DIV_QW), .DW(DIV_DW)) u_div_xa (
		.clk (clk), .arst_n (arst_n), .in_valid (fr_valid), .num (num_xa), .den (den_a),
		.out_valid (dv_xa), .quot (q_xa), .rem_nz (nz_xa)
	);

	// The track state rides alongside the dividers.
	kalp_side_t side_s [DIV_QW];

	always_ff @(posedge clk) begin
		side_s[0] <= fr_side;
		for (int i = 1; i < DIV_QW; i++) begin
			side_s[i] <= side_s[i-1];
		end
	end

	kalp_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.in_valid      (dv_xr),
		.side          (side_s[DIV_QW-1]),
		.q_vr          (q_vr),
		.q_va          (q_va),
		.q_xr          (q_xr),
		.q_xa          (q_xa),
		.nz_xr         (nz_xr),
		.nz_xa         (nz_xa),
		.done          (done),
		.new_range     (new_range),
		.new_angle     (new_angle),
		.new_range_var (new_range_var),
		.new_angle_var (new_angle_var),
		.keep_track    (keep_track)
	);

	localparam logic signed [DATA_W-1:0] PI_D = DATA_W'(PI_Q);

	// The four dividers run in lockstep.
	a_div_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		dv_xr == dv_xa && dv_xr == dv_vr && dv_xr == dv_va)
		else $error("divider valid bits out of step");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("track beat did not leave after the pipeline latency");

	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (new_angle > -PI_D && new_angle <= PI_D))
		else $error("new_angle outside the wrapped range");

	a_keep_gate: assert property (@(posedge clk) disable iff (!arst_n)
		(done && keep_track) |->
		(new_range_var < cfg_q.rv_limit && new_angle_var < cfg_q.av_limit))
		else $error("keep_track set with a variance over its limit");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the polar track Kalman update. Tracks are driven
// with random gaps, each accepted beat is run through a local predictor, and
// every done beat is compared field by field with the oldest prediction.
// Noise and limit registers are rewritten between phases while idle.
// ---------------------------------------------------------------------------
module tb;
	import kalp_pkg::*;

	localparam longint PI_L  = 25736;
	localparam longint TPI_L = 51472;
	localparam longint NPI_L = 82;
	localparam int     DRAIN = 60;

	typedef struct packed {
		logic [15:0] tr;
		logic [15:0] ta;
		logic [23:0] tpr;
		logic [23:0] tpa;
		logic [15:0] mr;
		logic [15:0] ma;
		logic [15:0] lv;
		logic [15:0] av;
		logic [15:0] dt;
	} track_in_t;

	typedef struct packed {
		logic [15:0] rng;
		logic [15:0] ang;
		logic [23:0] rvar;
		logic [23:0] avar;
		logic        keep;
	} track_out_t;

	class track_scoreboard;
		logic [23:0] regs [6];
		track_out_t  pending [$];
		int          errors;

		function new();
			regs[CFG_PN_RANGE] = 24'd458752;
			regs[CFG_PN_ANGLE] = 24'd1144;
			regs[CFG_MN_RANGE] = 24'd458752;
			regs[CFG_MN_ANGLE] = 24'd1144;
			regs[CFG_RV_LIMIT] = 24'd2293760;
			regs[CFG_AV_LIMIT] = 24'd5719;
			errors = 0;
		endfunction

		function longint fdiv(longint n, longint d);
			longint q;
			q = n / d;
			if ((n % d) != 0 && n < 0) q--;
			return q;
		endfunction

		function longint rdiv(longint n, longint d);
			return fdiv(2 * n + d, 2 * d);
		endfunction

		function longint wrap(longint a);
			longint n;
			n = PI_L - a;
			return PI_L - (n - fdiv(n, TPI_L) * TPI_L);
		endfunction

		function void note_track(track_in_t t);
			longint xr, xa, pr, pa, r, den, mr, ma, npr, npa;
			track_out_t o;
			xr = longint'($signed(t.tr)) + rdiv(longint'($signed(t.lv)) * t.dt, 256);
			xa = wrap($signed(t.ta)) + rdiv(longint'($signed(t.av)) * t.dt, 256);
			pr = longint'(t.tpr) + regs[CFG_PN_RANGE];
			pa = longint'(t.tpa) + regs[CFG_PN_ANGLE];
			mr = $signed(t.mr);
			ma = wrap($signed(t.ma));
			if (mr > 0) begin
				r = regs[CFG_MN_RANGE];
				den = pr + r;
				if (den == 0) npr = 0;
				else begin
					npr = rdiv(pr * r, den);
					xr = xr + rdiv(pr * (mr - xr), den);
				end
				r = regs[CFG_MN_ANGLE];
				den = pa + r;
				if (den == 0) npa = 0;
				else begin
					npa = rdiv(pa * r, den);
					xa = xa + rdiv(pa * (ma - xa), den);
				end
				pr = npr;
				pa = npa;
			end
			xa = wrap(xa);
			if (xa + PI_L < NPI_L) xa = -xa;
			if (xr > 32767) xr = 32767;
			if (xr < -32768) xr = -32768;
			if (pr > 24'hFFFFFF) pr = 24'hFFFFFF;
			if (pa > 24'hFFFFFF) pa = 24'hFFFFFF;
			o.rng  = xr[15:0];
			o.ang  = xa[15:0];
			o.rvar = pr[23:0];
			o.avar = pa[23:0];
			o.keep = (pr < regs[CFG_RV_LIMIT]) && (pa < regs[CFG_AV_LIMIT]);
			pending = {pending, o};
		endfunction

		function void check_result(track_out_t got);
			track_out_t e;
			if (pending.size() == 0) begin
				$error("unexpected result beat");
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.rng !== e.rng) begin
				$error("new_range exp %0h got %0h", e.rng, got.rng); errors++;
			end
			if (got.ang !== e.ang) begin
				$error("new_angle exp %0h got %0h", e.ang, got.ang); errors++;
			end
			if (got.rvar !== e.rvar) begin
				$error("new_range_var exp %0h got %0h", e.rvar, got.rvar); errors++;
			end
			if (got.avar !== e.avar) begin
				$error("new_angle_var exp %0h got %0h", e.avar, got.avar); errors++;
			end
			if (got.keep !== e.keep) begin
				$error("keep_track exp %0b got %0b", e.keep, got.keep); errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0, arst_n = 1'b0;
	logic start = 1'b0, busy, cfg_we = 1'b0, done, keep_track;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [VAR_W-1:0] cfg_data = '0, track_range_var = '0, track_angle_var = '0;
	logic [VAR_W-1:0] new_range_var, new_angle_var;
	logic signed [DATA_W-1:0] track_range = '0, track_angle = '0, meas_range = '0;
	logic signed [DATA_W-1:0] meas_angle = '0, linear_velocity = '0;
	logic signed [DATA_W-1:0] angular_velocity = '0, new_range, new_angle;
	logic [DATA_W-1:0] elapsed_time = '0;

	track_scoreboard tracks_sb = new();
	int gap_pct;

	polar_track_kalman_update i_dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (start && !busy) tracks_sb.note_track({track_range, track_angle,
			track_range_var, track_angle_var, meas_range, meas_angle,
			linear_velocity, angular_velocity, elapsed_time});
		if (done) tracks_sb.check_result({new_range, new_angle, new_range_var,
			new_angle_var, keep_track});
	end

	// Start stays high into the next beat; idle cycles and drain() lower it.
	task automatic send_track(track_in_t t);
		while ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		{track_range, track_angle, track_range_var, track_angle_var, meas_range,
			meas_angle, linear_velocity, angular_velocity, elapsed_time} <= t;
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [23:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we    <= 1'b0;
		tracks_sb.regs[idx] = val;
	endtask

	task automatic drain();
		start <= 1'b0;
		while (tracks_sb.pending.size() != 0) @(negedge clk);
		repeat (DRAIN) @(negedge clk);
	endtask

	// Mostly well-formed tracks: modest dt, realistic variances, often measured.
	function automatic track_in_t rand_track();
		track_in_t t;
		t.tr  = 16'($urandom);
		t.ta  = 16'($urandom);
		t.tpr = 24'($urandom);
		t.tpa = 24'($urandom);
		t.mr  = 16'($urandom);
		t.ma  = 16'($urandom);
		t.lv  = 16'($urandom);
		t.av  = 16'($urandom);
		t.dt  = 16'($urandom);
		case ($urandom_range(3))
			0: ;
			default: begin
				t.dt  = 16'($urandom_range(512));
				t.tpr = 24'($urandom_range(24'h0FFFFF));
				t.tpa = 24'($urandom_range(24'h00FFFF));
				t.tr  = 16'($urandom_range(16'h3FFF));
				t.mr  = ($urandom_range(4) == 0) ? 16'(-int'($urandom_range(300)))
					: 16'($urandom_range(16'h7FFF));
				t.lv  = 16'(int'($urandom_range(2048)) - 1024);
				t.av  = 16'(int'($urandom_range(8192)) - 4096);
			end
		endcase
		return t;
	endfunction

	task automatic directed();
		track_in_t t;
		t = '0; send_track(t);
		t = '1; send_track(t);
		t = {16'h7FFF, 16'h7FFF, 24'hFFFFFF, 24'hFFFFFF, 16'h7FFF, 16'h8000,
			16'h7FFF, 16'h7FFF, 16'hFFFF}; send_track(t);
		t = {16'h8000, 16'h8000, 24'h0, 24'h0, 16'h0001, 16'h7FFF,
			16'h8000, 16'h8000, 16'hFFFF}; send_track(t);
		// Bearings at and near plus or minus pi, with and without a measurement.
		t = {16'd100, 16'(-25700), 24'd10, 24'd10, 16'd0, 16'd0, 16'd0, 16'd0,
			16'd0}; send_track(t);
		t = {16'd100, 16'(-25736), 24'd10, 24'd10, 16'(-5), 16'd0, 16'd0, 16'd0,
			16'd0}; send_track(t);
		t = {16'd100, 16'd25736, 24'd10, 24'd10, 16'd50, 16'(-25735), 16'd0, 16'd0,
			16'd0}; send_track(t);
		t = {16'd900, 16'd3000, 24'd65536, 24'd1000, 16'd1000, 16'd3100,
			16'd256, 16'd82, 16'd256}; send_track(t);
	endtask

	initial begin
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		gap_pct = 21;
		directed();
		drain();
		// Zero noise and zero variances exercise the zero gain denominator.
		write_reg(CFG_PN_RANGE, 24'd0);
		write_reg(CFG_PN_ANGLE, 24'd0);
		write_reg(CFG_MN_RANGE, 24'd0);
		write_reg(CFG_MN_ANGLE, 24'd0);
		write_reg(CFG_RV_LIMIT, 24'd0);
		write_reg(CFG_AV_LIMIT, 24'hFFFFFF);
		send_track({16'd100, 16'd200, 24'd0, 24'd0, 16'd300, 16'd400,
			16'd0, 16'd0, 16'd0});
		for (int i = 0; i < 150; i++) send_track(rand_track());
		drain();
		gap_pct = 49;
		write_reg(CFG_PN_RANGE, 24'hFFFFFF);
		write_reg(CFG_PN_ANGLE, 24'hFFFFFF);
		write_reg(CFG_MN_RANGE, 24'hFFFFFF);
		write_reg(CFG_MN_ANGLE, 24'hFFFFFF);
		write_reg(CFG_RV_LIMIT, 24'hFFFFFF);
		write_reg(CFG_AV_LIMIT, 24'd0);
		for (int i = 0; i < 150; i++) send_track(rand_track());
		drain();
		gap_pct = 0;
		for (int p = 0; p < 3; p++) begin
			for (int r = 0; r < 6; r++)
				write_reg(cfg_idx_t'(r), 24'($urandom_range(24'h0FFFFF)));
			for (int i = 0; i < 115; i++) send_track(rand_track());
			drain();
		end
		if (tracks_sb.errors == 0 && tracks_sb.pending.size() == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

	initial begin
		#2ms;
		$display("tb NOT OK");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/kalp_pkg.sv
hdl/kalp_divider.sv
hdl/kalp_front.sv
hdl/kalp_back.sv
hdl/polar_track_kalman_update.sv
verif/tb.sv
